### src/pipt_pkg.sv
// Shared types and constants of the point-in-polygon test unit.
package pipt_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int ENTRY_W = 2 * COORD_W;
  localparam int CFG_W   = 7;

  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(3);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN_RD,
    ST_SPAN_UPD,
    ST_SPAN_CHK,
    ST_E_RD1,
    ST_E_RD2,
    ST_E_LD2,
    ST_E_TEST,
    ST_E_MUL,
    ST_E_DSTART,
    ST_E_DWAIT,
    ST_E_CMP,
    ST_E_NEXT,
    ST_DONE
  } pipt_state_e;

endpackage

### src/pipt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pipt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/pipt_div.sv
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
module pipt_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [pipt_pkg::PROD_W-1:0]   num_i,
  input  logic signed [pipt_pkg::DIFF_W-1:0]   den_i,
  output logic                                 done_o,
  output logic signed [pipt_pkg::PROD_W-1:0]   quo_o
);
  import pipt_pkg::*;

  localparam int CNTW = $clog2(PROD_W + 1);

  logic              busy_q, done_q, neg_q;
  logic [CNTW-1:0]   cnt_q;
  logic [DIFF_W-1:0] rem_q, dmag_q;
  logic [PROD_W-1:0] dvd_q;

  logic [PROD_W-1:0] num_mag;
  logic [DIFF_W-1:0] den_mag;
  logic [DIFF_W:0]   trial;
  logic              fits;

  assign num_mag = num_i[PROD_W-1] ? PROD_W'(-num_i) : PROD_W'(num_i);
  assign den_mag = den_i[DIFF_W-1] ? DIFF_W'(-den_i) : DIFF_W'(den_i);
  assign trial   = {rem_q, dvd_q[PROD_W-1]};
  assign fits    = trial >= {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CNTW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(PROD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dvd_q  <= num_mag;
      dmag_q <= den_mag;
      neg_q  <= num_i[PROD_W-1] ^ den_i[DIFF_W-1];
    end else if (busy_q) begin
      rem_q <= fits ? DIFF_W'(trial - {1'b0, dmag_q}) : trial[DIFF_W-1:0];
      dvd_q <= {dvd_q[PROD_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -signed'(dvd_q) : signed'(dvd_q);

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider busy with empty count");
`endif

endmodule

### src/point_in_polygon_test_unit.sv
// Top level of the point-in-polygon test unit: sequencer, datapath and vertex store.
// A query scans the vertices for the y span and, if the point lies within it, walks the edges;
// it waits on the one-bit-per-cycle divider for each edge that needs it.
// One item is worked on at a time; the next is accepted while a result waits.
// Reset (rst_ni low, asynchronous) clears control state and sets vertex_count to 3;
// the vertex store is not cleared and is undefined until written.
module point_in_polygon_test_unit #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [5:0] vertex_index, [21:6] coord_x, [37:22] coord_y, [39:38] zero
  input  logic [39:0]                   s_axis_tdata_i,
  // [0] opcode
  input  logic [0:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] inside_res, [7:1] zero
  output logic [7:0]                    m_axis_tdata_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pipt_pkg::CFG_W-1:0]    cfg_data_i
);
  import pipt_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int NW = (CW > CFG_W) ? CW : CFG_W;
  localparam int SW = PROD_W + 1;

  pipt_state_e state_q, state_d;

  logic [CFG_W-1:0]          count_q;
  logic [CW-1:0]             n_q, idx_q;
  logic signed [COORD_W-1:0] px_q, py_q, lo_q, hi_q, x1_q, y1_q, x2_q, y2_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      parity_q, out_valid_q, out_data_q;

  logic                      in_op;
  logic [5:0]                in_idx;
  logic signed [COORD_W-1:0] in_x, in_y, rd_x, rd_y;
  logic [NW-1:0]             count_ext, n_ext;
  logic [CW-1:0]             n_now, idx_inc, idx_nxt;
  logic                      last_vtx, in_range;
  logic signed [COORD_W-1:0] ymin, ymax, xmax;
  logic signed [DIFF_W-1:0]  dy, dx, dden;
  logic                      edge_cond, vertical, cross_hit, out_load;
  logic signed [PROD_W-1:0]  quo;
  logic signed [SW-1:0]      cmp_lhs, cmp_rhs;
  logic                      div_start, div_done;
  logic                      ram_we;
  logic [AW-1:0]             ram_raddr;
  logic [ENTRY_W-1:0]        ram_rdata;

  assign in_op  = s_axis_tuser_i[0];
  assign in_idx = s_axis_tdata_i[5:0];
  assign in_x   = signed'(s_axis_tdata_i[21:6]);
  assign in_y   = signed'(s_axis_tdata_i[37:22]);
  assign rd_x   = signed'(ram_rdata[COORD_W-1:0]);
  assign rd_y   = signed'(ram_rdata[ENTRY_W-1:COORD_W]);

  // A count above the store depth is treated as the full depth.
  assign count_ext = NW'(count_q);
  assign n_ext     = (count_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : count_ext;
  assign n_now     = n_ext[CW-1:0];
  assign in_range  = {26'b0, in_idx} < 32'(MAX_VERTICES);

  assign idx_inc  = idx_q + CW'(1);
  assign last_vtx = (idx_inc == n_q);
  assign idx_nxt  = last_vtx ? '0 : idx_inc;

  assign ymin = (y1_q < y2_q) ? y1_q : y2_q;
  assign ymax = (y1_q < y2_q) ? y2_q : y1_q;
  assign xmax = (x1_q < x2_q) ? x2_q : x1_q;
  assign dy   = DIFF_W'(py_q) - DIFF_W'(y1_q);
  assign dx   = DIFF_W'(x2_q) - DIFF_W'(x1_q);
  assign dden = DIFF_W'(y2_q) - DIFF_W'(y1_q);

  // A horizontal edge never meets the y window, so it never reaches the divider.
  assign edge_cond = (py_q > ymin) && (py_q <= ymax) && (px_q <= xmax);
  assign vertical  = (x1_q == x2_q);
  assign cmp_lhs   = SW'(px_q);
  assign cmp_rhs   = SW'(x1_q) + SW'(quo);
  assign cross_hit = (cmp_lhs <= cmp_rhs);
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  pipt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_idx)),
    .wdata_i ({in_y, in_x}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pipt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (dden),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i && in_op == OPC_QUERY) begin
          state_d = (n_now == '0) ? ST_DONE : ST_SPAN_RD;
        end
      end
      ST_SPAN_RD:  state_d = ST_SPAN_UPD;
      ST_SPAN_UPD: state_d = last_vtx ? ST_SPAN_CHK : ST_SPAN_RD;
      ST_SPAN_CHK: state_d = (py_q > hi_q || py_q < lo_q) ? ST_DONE : ST_E_RD1;
      ST_E_RD1:    state_d = ST_E_RD2;
      ST_E_RD2:    state_d = ST_E_LD2;
      ST_E_LD2:    state_d = ST_E_TEST;
      ST_E_TEST:   state_d = (edge_cond && !vertical) ? ST_E_MUL : ST_E_NEXT;
      ST_E_MUL:    state_d = ST_E_DSTART;
      ST_E_DSTART: state_d = ST_E_DWAIT;
      ST_E_DWAIT:  state_d = div_done ? ST_E_CMP : ST_E_DWAIT;
      ST_E_CMP:    state_d = ST_E_NEXT;
      ST_E_NEXT:   state_d = last_vtx ? ST_DONE : ST_E_RD1;
      ST_DONE:     state_d = out_load ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    ram_we          = (state_q == ST_IDLE) && s_axis_tvalid_i && (in_op == OPC_WRITE)
                      && in_range;
    // The second read of an edge fetches the vertex that follows, wrapping to zero.
    ram_raddr       = (state_q == ST_E_RD2) ? idx_nxt[AW-1:0] : idx_q[AW-1:0];
    div_start       = (state_q == ST_E_DSTART);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= parity_q;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i && in_op == OPC_QUERY) begin
          px_q     <= in_x;
          py_q     <= in_y;
          n_q      <= n_now;
          idx_q    <= '0;
          parity_q <= 1'b0;
        end
      end
      ST_SPAN_UPD: begin
        if (idx_q == '0) begin
          lo_q <= rd_y;
          hi_q <= rd_y;
        end else begin
          if (rd_y < lo_q) lo_q <= rd_y;
          if (rd_y > hi_q) hi_q <= rd_y;
        end
        idx_q <= idx_inc;
      end
      ST_SPAN_CHK: idx_q <= '0;
      ST_E_RD2: begin
        x1_q <= rd_x;
        y1_q <= rd_y;
      end
      ST_E_LD2: begin
        x2_q <= rd_x;
        y2_q <= rd_y;
      end
      ST_E_TEST: begin
        if (edge_cond && vertical) parity_q <= ~parity_q;
      end
      ST_E_MUL:  prod_q <= dy * dx;
      ST_E_CMP: begin
        if (cross_hit) parity_q <= ~parity_q;
      end
      ST_E_NEXT: idx_q <= idx_inc;
      default: begin
      end
    endcase
  end

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_data_q};

`ifndef SYNTHESIS
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result word raised outside the done state");
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_E_DWAIT)
    else $error("divider finished while the sequencer was not waiting");
  a_edge_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_E_RD1 |-> idx_q < n_q)
    else $error("edge index beyond vertex count");
`endif

endmodule

### tb/point_in_polygon_test_unit_checker.sv
`timescale 1ns / 100ps
// Checker for the point-in-polygon test unit: watches all channels, predicts and compares results.
module point_in_polygon_test_unit_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  input  logic                       s_axis_tready_i,
  // [5:0] vertex_index, [21:6] coord_x, [37:22] coord_y, [39:38] zero
  input  logic [39:0]                s_axis_tdata_i,
  // [0] opcode
  input  logic [0:0]                 s_axis_tuser_i,
  input  logic                       m_axis_tvalid_i,
  input  logic                       m_axis_tready_i,
  // [0] inside_res, [7:1] zero
  input  logic [7:0]                 m_axis_tdata_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [pipt_pkg::CFG_W-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import pipt_pkg::*;

  localparam int MAX_VERTS = 64;

  logic signed [COORD_W-1:0] vert_x [MAX_VERTS];
  logic signed [COORD_W-1:0] vert_y [MAX_VERTS];
  logic [CFG_W-1:0]          vertex_count;
  logic                      inside_expected_q [$];

  // Crossing-number parity over the closed polygon, with exact wide arithmetic.
  function automatic logic inside_by_crossings(input int px, input int py);
    int n, lo_y, hi_y, j, x1, y1, x2, y2;
    longint quot;
    logic odd;
    n = (int'(vertex_count) > MAX_VERTS) ? MAX_VERTS : int'(vertex_count);
    if (n == 0) return 1'b0;
    lo_y = vert_y[0];
    hi_y = vert_y[0];
    for (int i = 0; i < n; i++) begin
      if (vert_y[i] > hi_y) hi_y = vert_y[i];
      if (vert_y[i] < lo_y) lo_y = vert_y[i];
    end
    if (py > hi_y || py < lo_y) return 1'b0;
    odd = 1'b0;
    for (int i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      x1 = vert_x[i];
      y1 = vert_y[i];
      x2 = vert_x[j];
      y2 = vert_y[j];
      if (py > ((y1 < y2) ? y1 : y2) && py <= ((y1 < y2) ? y2 : y1) &&
          px <= ((x1 < x2) ? x2 : x1)) begin
        if (x1 == x2) begin
          odd = ~odd;
        end else if (y1 != y2) begin
          quot = (longint'(py - y1) * longint'(x2 - x1)) / longint'(y2 - y1);
          if (longint'(px) <= longint'(x1) + quot) odd = ~odd;
        end
      end
    end
    return odd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count = COUNT_RESET;
      inside_expected_q.delete();
      pending_o = 0;
    end else begin
      // The result side is handled first: a result always belongs to an older query.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (inside_expected_q.size() == 0) begin
          $error("inside_res: no result expected, actual %0d", m_axis_tdata_i[0]);
          fail_count_o++;
        end else if (m_axis_tdata_i[0] !== inside_expected_q[0]) begin
          $error("inside_res mismatch: expected %0d, actual %0d",
                 inside_expected_q[0], m_axis_tdata_i[0]);
          fail_count_o++;
          void'(inside_expected_q.pop_front());
        end else begin
          void'(inside_expected_q.pop_front());
        end
      end
      if (cfg_valid_i && cfg_ready_i) vertex_count = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i[0] == OPC_QUERY) begin
          inside_expected_q.push_back(inside_by_crossings(
              int'(signed'(s_axis_tdata_i[21:6])), int'(signed'(s_axis_tdata_i[37:22]))));
        end else begin
          vert_x[s_axis_tdata_i[5:0]] = s_axis_tdata_i[21:6];
          vert_y[s_axis_tdata_i[5:0]] = s_axis_tdata_i[37:22];
        end
      end
      pending_o = inside_expected_q.size();
    end
  end

endmodule

### tb/point_in_polygon_test_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the point-in-polygon test unit: clock, reset, stimulus and verdict.
module point_in_polygon_test_unit_tb;
  import pipt_pkg::*;

  localparam int MAX_VERTS    = 64;
  localparam int ITEM_TARGET  = 270;
  localparam int LIMIT_CYCLES = 5_000_000;
  localparam int COORD_MIN    = -32768;
  localparam int COORD_MAX    = 32767;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [39:0]      s_axis_tdata_i  = '0;
  logic [0:0]       s_axis_tuser_i  = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [7:0]       m_axis_tdata_o;
  logic             cfg_valid_i     = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i      = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int items_sent  = 0;
  bit calm        = 1'b0;

  // Shadow of the polygon as written, used to aim query points.
  int                   shadow_x [MAX_VERTS];
  int                   shadow_y [MAX_VERTS];
  bit [MAX_VERTS-1:0]   written    = '0;
  int                   used_count = 3;

  point_in_polygon_test_unit #(
    .MAX_VERTICES(MAX_VERTS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  point_in_polygon_test_unit_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("point_in_polygon_test_unit test failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= 31);
  end

  function automatic int clamp16(input int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Mode 0 clusters around a center, mode 1 spans the full range, mode 2 snaps to a
  // coarse grid so that vertical and horizontal edges and equal coordinates show up.
  function automatic int pick_coord(input int mode, input int center);
    case (mode)
      0:       return clamp16(center + rand_between(-300, 300));
      1:       return rand_between(COORD_MIN, COORD_MAX);
      default: return ($urandom_range(3) == 0) ? COORD_MAX : rand_between(-4, 3) * 8192;
    endcase
  endfunction

  task automatic push_word(input logic opc, input int idx, input int x, input int y);
    bit sent;
    sent = 1'b0;
    calm = (items_sent >= 110 && items_sent < 170);
    while (!sent) begin
      @(negedge clk_i);
      if (!calm && $urandom_range(99) < 31) begin
        s_axis_tvalid_i <= 1'b0;
        s_axis_tdata_i  <= {8'($urandom), $urandom};
        s_axis_tuser_i  <= 1'($urandom);
      end else begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {2'b00, y[15:0], x[15:0], idx[5:0]};
        s_axis_tuser_i  <= opc;
        do @(posedge clk_i); while (!s_axis_tready_o);
        sent = 1'b1;
      end
    end
    items_sent++;
    if (opc == OPC_WRITE) begin
      shadow_x[idx] = x;
      shadow_y[idx] = y;
      written[idx]  = 1'b1;
    end
  endtask

  // The register is only written once every expected result has come back.
  task automatic set_vertex_count(input int value);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value[CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    used_count = value;
  endtask

  task automatic pick_query(output int qx, output int qy);
    int k, lo_x, hi_x, lo_y, hi_y, v, sel;
    k   = (used_count > MAX_VERTS) ? MAX_VERTS : used_count;
    sel = $urandom_range(9);
    if (k == 0 || sel == 8) begin
      qx = rand_between(COORD_MIN, COORD_MAX);
      qy = rand_between(COORD_MIN, COORD_MAX);
    end else begin
      lo_x = shadow_x[0];
      hi_x = shadow_x[0];
      lo_y = shadow_y[0];
      hi_y = shadow_y[0];
      for (int i = 1; i < k; i++) begin
        if (shadow_x[i] < lo_x) lo_x = shadow_x[i];
        if (shadow_x[i] > hi_x) hi_x = shadow_x[i];
        if (shadow_y[i] < lo_y) lo_y = shadow_y[i];
        if (shadow_y[i] > hi_y) hi_y = shadow_y[i];
      end
      v = $urandom_range(k - 1);
      case (sel)
        4, 5: begin
          qx = shadow_x[v];
          qy = shadow_y[v];
        end
        6: begin
          qx = shadow_x[v];
          qy = clamp16(shadow_y[v] + rand_between(-1, 1));
        end
        7: begin
          qx = clamp16(shadow_x[v] + rand_between(-1, 1));
          qy = shadow_y[v];
        end
        9: begin
          qx = rand_between(lo_x, hi_x);
          qy = (hi_y < COORD_MAX && $urandom_range(1)) ? hi_y + 1 : clamp16(lo_y - 1);
        end
        default: begin
          qx = rand_between(lo_x, hi_x);
          qy = rand_between(lo_y, hi_y);
        end
      endcase
    end
  endtask

  initial begin
    int phase, r, new_count, k, mode, center, nq, qx, qy, idx;
    bit rewrite;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Triangle on the coordinate extremes with a horizontal bottom edge.
    push_word(OPC_WRITE, 0, COORD_MIN, COORD_MIN);
    push_word(OPC_WRITE, 1, COORD_MAX, COORD_MIN);
    push_word(OPC_WRITE, 2, 0, COORD_MAX);
    push_word(OPC_QUERY, 0, 0, 0);
    push_word(OPC_QUERY, 63, COORD_MIN, COORD_MIN);
    push_word(OPC_QUERY, 0, COORD_MAX, COORD_MAX);
    push_word(OPC_QUERY, 0, COORD_MIN, 0);
    push_word(OPC_QUERY, 0, 0, COORD_MAX);
    // Turn the right edge vertical.
    push_word(OPC_WRITE, 2, COORD_MAX, COORD_MAX);
    push_word(OPC_QUERY, 0, COORD_MAX, 0);
    push_word(OPC_QUERY, 0, 100, 0);
    push_word(OPC_QUERY, 0, 0, COORD_MIN + 1);
    push_word(OPC_WRITE, 63, COORD_MAX, COORD_MAX);
    // Degenerate counts: none, a single vertex and a single horizontal segment.
    set_vertex_count(0);
    push_word(OPC_QUERY, 0, 0, 0);
    set_vertex_count(1);
    push_word(OPC_QUERY, 0, COORD_MIN, COORD_MIN);
    set_vertex_count(2);
    push_word(OPC_QUERY, 0, 0, COORD_MIN);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      if (phase == 1) begin
        new_count = MAX_VERTS;
      end else if (phase == 3) begin
        new_count = (1 << CFG_W) - 1;
      end else begin
        r = $urandom_range(99);
        if (r < 4)       new_count = rand_between(MAX_VERTS + 1, (1 << CFG_W) - 1);
        else if (r < 7)  new_count = MAX_VERTS;
        else if (r < 14) new_count = rand_between(0, 2);
        else             new_count = rand_between(3, 12);
      end
      set_vertex_count(new_count);
      k       = (new_count > MAX_VERTS) ? MAX_VERTS : new_count;
      mode    = $urandom_range(2);
      center  = rand_between(-32000, 32000);
      rewrite = (k <= 16);
      for (int i = 0; i < k; i++) begin
        if (!written[i] || rewrite)
          push_word(OPC_WRITE, i, pick_coord(mode, center), pick_coord(mode, center));
      end
      if (!rewrite) begin
        repeat ($urandom_range(6, 1)) begin
          idx = $urandom_range(k - 1);
          push_word(OPC_WRITE, idx, pick_coord(mode, center), pick_coord(mode, center));
        end
      end
      nq = (k == MAX_VERTS) ? rand_between(3, 5) : rand_between(4, 10);
      repeat (nq) begin
        // Stray writes land anywhere in the store, in use or not.
        if ($urandom_range(4) == 0)
          push_word(OPC_WRITE, $urandom_range(MAX_VERTS - 1),
                    pick_coord(mode, center), pick_coord(mode, center));
        pick_query(qx, qy);
        push_word(OPC_QUERY, $urandom_range(MAX_VERTS - 1), qx, qy);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("point_in_polygon_test_unit test passed");
    end else begin
      $display("point_in_polygon_test_unit test failed");
    end
    $finish;
  end

endmodule

### sim.f
src/pipt_pkg.sv
src/pipt_ram.sv
src/pipt_div.sv
src/point_in_polygon_test_unit.sv
tb/point_in_polygon_test_unit_checker.sv
tb/point_in_polygon_test_unit_tb.sv
